### rtl/selection_sort_engine_assert.svh
// Assertion macros shared by the selection sort engine RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef SELECTION_SORT_ENGINE_ASSERT_SVH
`define SELECTION_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sse check failed");

// Next-cycle implication, disabled during reset.
`define SSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sse check failed");

`endif

### rtl/sse_pkg.sv
// Shared types and constants of the selection sort engine.
// Used by every module of the block but sse_ram; depends on nothing.
`timescale 1ns / 1ps

package sse_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_W     = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified request on its way from the front to the back.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [ADDR_W-1:0]         addr;
      logic                      wr;
      logic                      last;
      logic                      ovf;
      logic [CNT_W-1:0]          count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT_RD,
      ST_EMIT_LD
   } back_state_type;

endpackage

### rtl/selection_sort_engine.sv
// Channel    | Direction | Ports
// request    | in        | req_push, req_full, req_value, req_last
// response   | out       | rsp_pop, rsp_empty, rsp_sorted_value, rsp_final_res, rsp_overflow
//
// A request that does not close a set is popped and, if it fits, written to the store while the back end stays idle.
// A closing request of a set of n >= 2 elements sorts by store reads and swap writes,
// then emits the responses one by one, each read from the store before it is loaded.
// Reset is synchronous; the store needs no clearing pass.
// The two-entry request queue takes up to two requests while a set is sorted or a
// response waits.
// Top level of the selection sort engine. Depends on sse_pkg, sse_front,
// sse_queue and sse_back.
`timescale 1ns / 1ps

module selection_sort_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [sse_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [sse_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                               rsp_final_res,
   output logic                               rsp_overflow
);

   sse_pkg::entry_type fq_entry;
   sse_pkg::entry_type qb_entry;
   logic               fq_push;
   logic               fq_full;
   logic               qb_pop;
   logic               qb_empty;

   sse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_last  (req_last),
      .q_push    (fq_push),
      .q_entry   (fq_entry),
      .q_full    (fq_full)
   );

   sse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .entry_in  (fq_entry),
      .full      (fq_full),
      .pop       (qb_pop),
      .entry_out (qb_entry),
      .empty     (qb_empty)
   );

   sse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (qb_empty),
      .q_entry          (qb_entry),
      .q_pop            (qb_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

### rtl/sse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sse_front.sv
// Front end: accepts requests, assigns store slots and flags dropped elements.
// Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [sse_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               q_push,
   output sse_pkg::entry_type                 q_entry,
   input  logic                               q_full
);

   logic [sse_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      drop_ff, drop_in;
   logic                      fits;
   logic [sse_pkg::CNT_W-1:0] count_next;

   assign req_full   = q_full;
   assign q_push     = req_push && !q_full;
   assign fits       = count_ff < sse_pkg::CNT_W'(sse_pkg::DEPTH);
   assign count_next = fits ? count_ff + sse_pkg::CNT_W'(1) : count_ff;

   always_comb begin
      q_entry.value = req_value;
      q_entry.addr  = count_ff[sse_pkg::ADDR_W-1:0];
      q_entry.wr    = fits;
      q_entry.last  = req_last;
      q_entry.ovf   = drop_ff || !fits;
      q_entry.count = count_next;

      count_in = count_ff;
      drop_in  = drop_ff;
      if (q_push) begin
         // The last request closes the set, so the next one starts clean.
         if (req_last) begin
            count_in = '0;
            drop_in  = 1'b0;
         end else begin
            count_in = count_next;
            drop_in  = drop_ff || !fits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

### rtl/sse_queue.sv
// Short queue of classified requests between the front and the back.
// Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sse_pkg::entry_type entry_in,
   output logic               full,
   input  logic               pop,
   output sse_pkg::entry_type entry_out,
   output logic               empty
);

   sse_pkg::entry_type         slot_ff [sse_pkg::QUEUE_DEPTH];
   logic [sse_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sse_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sse_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full      = count_ff == sse_pkg::QCNT_W'(sse_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign entry_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + sse_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + sse_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + sse_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sse_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### rtl/sse_back.sv
// Back end: writes elements to the store, sorts a closed set by selection
// and streams it out through an output register. Depends on sse_pkg, sse_ram.
`timescale 1ns / 1ps
`include "selection_sort_engine_assert.svh"

module sse_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  sse_pkg::entry_type                 q_entry,
   output logic                               q_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic signed [sse_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                               rsp_final_res,
   output logic                               rsp_overflow
);

   sse_pkg::back_state_type state_ff, state_in;

   logic [sse_pkg::CNT_W-1:0] n_ff, n_in;
   logic [sse_pkg::CNT_W-1:0] s_ff, s_in;
   logic [sse_pkg::CNT_W-1:0] i_ff, i_in;
   logic [sse_pkg::CNT_W-1:0] didx_ff, didx_in;
   logic [sse_pkg::CNT_W-1:0] pick_ff, pick_in;
   logic [sse_pkg::CNT_W-1:0] k_ff, k_in;
   logic                      ovf_ff, ovf_in;
   logic                      dv_ff, dv_in;
   logic signed [sse_pkg::VALUE_W-1:0] least_ff, least_in;
   logic signed [sse_pkg::VALUE_W-1:0] first_ff, first_in;

   logic                               out_valid_ff, out_valid_in;
   logic signed [sse_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic                               out_final_ff, out_final_in;
   logic                               out_ovf_ff, out_ovf_in;
   logic                               load;

   logic                               ram_we;
   logic [sse_pkg::ADDR_W-1:0]         ram_waddr;
   logic [sse_pkg::VALUE_W-1:0]        ram_wdata;
   logic [sse_pkg::ADDR_W-1:0]         ram_raddr;
   logic [sse_pkg::VALUE_W-1:0]        ram_rdata;
   logic signed [sse_pkg::VALUE_W-1:0] rd_value;

   sse_ram #(
      .WIDTH (sse_pkg::VALUE_W),
      .DEPTH (sse_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_value = $signed(ram_rdata);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      i_in      = i_ff;
      didx_in   = didx_ff;
      pick_in   = pick_ff;
      k_in      = k_ff;
      ovf_in    = ovf_ff;
      dv_in     = 1'b0;
      least_in  = least_ff;
      first_in  = first_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      load      = 1'b0;

      unique case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.wr) begin
                  ram_we    = 1'b1;
                  ram_waddr = q_entry.addr;
                  ram_wdata = q_entry.value;
               end
               if (q_entry.last) begin
                  n_in   = q_entry.count;
                  ovf_in = q_entry.ovf;
                  s_in   = '0;
                  i_in   = '0;
                  k_in   = '0;
                  if (q_entry.count == sse_pkg::CNT_W'(1)) begin
                     state_in = sse_pkg::ST_EMIT_RD;
                  end else begin
                     state_in = sse_pkg::ST_SCAN;
                  end
               end
            end
         end
         sse_pkg::ST_SCAN: begin
            // Reads are issued one a cycle; the data of the previous
            // address is compared while the next one is fetched.
            if (i_ff < n_ff) begin
               ram_raddr = i_ff[sse_pkg::ADDR_W-1:0];
               i_in      = i_ff + sse_pkg::CNT_W'(1);
               dv_in     = 1'b1;
               didx_in   = i_ff;
            end
            if (dv_ff) begin
               if (didx_ff == s_ff) begin
                  least_in = rd_value;
                  first_in = rd_value;
                  pick_in  = s_ff;
               end else if (rd_value < least_ff) begin
                  least_in = rd_value;
                  pick_in  = didx_ff;
               end
               if (didx_ff == n_ff - sse_pkg::CNT_W'(1)) begin
                  state_in = sse_pkg::ST_SWAP_A;
               end
            end
         end
         sse_pkg::ST_SWAP_A: begin
            ram_we    = 1'b1;
            ram_waddr = pick_ff[sse_pkg::ADDR_W-1:0];
            ram_wdata = first_ff;
            state_in  = sse_pkg::ST_SWAP_B;
         end
         sse_pkg::ST_SWAP_B: begin
            ram_we    = 1'b1;
            ram_waddr = s_ff[sse_pkg::ADDR_W-1:0];
            ram_wdata = least_ff;
            s_in      = s_ff + sse_pkg::CNT_W'(1);
            if (s_ff + sse_pkg::CNT_W'(2) == n_ff) begin
               k_in     = '0;
               state_in = sse_pkg::ST_EMIT_RD;
            end else begin
               i_in     = s_ff + sse_pkg::CNT_W'(1);
               state_in = sse_pkg::ST_SCAN;
            end
         end
         sse_pkg::ST_EMIT_RD: begin
            ram_raddr = k_ff[sse_pkg::ADDR_W-1:0];
            state_in  = sse_pkg::ST_EMIT_LD;
         end
         sse_pkg::ST_EMIT_LD: begin
            // The address is held so the read data stays put while the
            // output register is still occupied.
            ram_raddr = k_ff[sse_pkg::ADDR_W-1:0];
            if (!out_valid_ff || rsp_pop) begin
               load = 1'b1;
               if (k_ff == n_ff - sse_pkg::CNT_W'(1)) begin
                  state_in = sse_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + sse_pkg::CNT_W'(1);
                  state_in = sse_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = sse_pkg::ST_IDLE;
         end
      endcase

      out_valid_in = (out_valid_ff && !rsp_pop) || load;
      out_value_in = load ? rd_value : out_value_ff;
      out_final_in = load ? (k_ff == n_ff - sse_pkg::CNT_W'(1)) : out_final_ff;
      out_ovf_in   = load ? ovf_ff : out_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         dv_ff        <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      s_ff         <= s_in;
      i_ff         <= i_in;
      didx_ff      <= didx_in;
      pick_ff      <= pick_in;
      k_ff         <= k_in;
      ovf_ff       <= ovf_in;
      least_ff     <= least_in;
      first_ff     <= first_in;
      out_value_ff <= out_value_in;
      out_final_ff <= out_final_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_final_res    = out_final_ff;
   assign rsp_overflow     = out_ovf_ff;

   `SSE_ASSERT_IMPL(a_no_overwrite, clock, reset, load && out_valid_ff, rsp_pop)
   `SSE_ASSERT_IMPL(a_pick_in_range, clock, reset, state_ff == sse_pkg::ST_SWAP_A,
                    pick_ff >= s_ff && pick_ff < n_ff)
   `SSE_ASSERT_NEXT(a_final_ends_run, clock, reset, load && out_final_in,
                    state_ff == sse_pkg::ST_IDLE)
   `SSE_ASSERT_IMPL(a_no_pop_while_busy, clock, reset, q_pop, state_ff == sse_pkg::ST_IDLE)

endmodule
